// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the ARP cache checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ARPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Sizes, codes and storage layouts shared by the ARP cache modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int CACHE_ENTRIES   = 128;
   localparam int PENDING_ENTRIES = 16;
   localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PIDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

   localparam logic [15:0] EXPIRY_RESET = 16'd15;
   localparam logic [7:0]  RESEND_RESET = 8'd1;
   localparam logic [2:0]  TRIES_RESET  = 3'd5;

   typedef enum logic [1:0] {
      CSR_EXPIRY = 2'd0,
      CSR_RESEND = 2'd1,
      CSR_TRIES  = 2'd2,
      CSR_SPARE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_QUEUE  = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      EV_MISS     = 4'd0,
      EV_HIT      = 4'd1,
      EV_INSERTED = 4'd2,
      EV_FULL     = 4'd3,
      EV_QUEUED   = 4'd4,
      EV_ALREADY  = 4'd5,
      EV_QFULL    = 4'd6,
      EV_SEND     = 4'd7,
      EV_GIVEUP   = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CSCAN,
      ST_PREAD,
      ST_PEXEC,
      ST_FREE,
      ST_QEND,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] added;
   } cache_entry_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [31:0] sent;
      logic [2:0]  tries;
   } pend_entry_type;

endpackage

// File: hw/rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// ARP cache RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module arpc_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/arp_cache_with_request_retry.sv
// ----------------------------------------------------------------------------
// ARP cache with request retry
// IPv4-to-MAC cache with ageing and a table of pending ARP requests.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel: tuser holds the kind (lookup, insert,
// queue, one-second tick) and tdata the address and MAC. Results leave on the
// rsp_ channel; tlast marks the final result of a command. Lookup, insert and
// queue give one result each; a tick gives one result per pending request that
// is acted on, possibly none. Registers are written through the csr_ port; the
// user must write them only while the block is idle; the block does not enforce it.
// One command is handled at a time. A lookup or a tick walks every cache slot
// through the cache RAM read port, one slot a cycle; an insert, a queue and the
// end of a tick walk the pending RAM slot by slot, each slot through the states
// PREAD and PEXEC, and an insert then searches the valid bits one slot a cycle.
// Reset clears all valid bits, the clock and the registers to their defaults;
// no clearing pass is needed. A stalled receiver holds the result register,
// and a tick waits in its pending walk until the transfer completes.
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry
   import arpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // ip[31:0], mac[79:32]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // event_res[3:0], addr_ip[35:4],
                                    // addr_mac[83:36], released[84], zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic [31:0] ip_ff, ip_in;
   logic [47:0] mac_ff, mac_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] expiry_ff;
   logic [7:0]  resend_ff;
   logic [2:0]  tries_ff;

   logic [CACHE_ENTRIES-1:0]   cvalid_ff, cvalid_in;
   logic [PENDING_ENTRIES-1:0] pvalid_ff, pvalid_in;
   logic [CIDX_W:0]   cidx_ff, cidx_in;
   logic              stg_valid_ff, stg_valid_in;
   logic [CIDX_W-1:0] stg_idx_ff, stg_idx_in;
   logic [PIDX_W-1:0] pidx_ff, pidx_in;

   logic        hit_ff, hit_in;
   logic [47:0] hit_mac_ff, hit_mac_in;
   logic        rel_ff, rel_in;
   logic        found_ff, found_in;
   logic        free_ok_ff, free_ok_in;
   logic [PIDX_W-1:0] free_idx_ff, free_idx_in;

   logic        hold_valid_ff, hold_valid_in;
   event_type   hold_ev_ff, hold_ev_in;
   logic [31:0] hold_ip_ff, hold_ip_in;
   logic [47:0] hold_mac_ff, hold_mac_in;
   logic        hold_rel_ff, hold_rel_in;

   logic        rsp_valid_ff, rsp_valid_in;
   event_type   rsp_ev_ff, rsp_ev_in;
   logic [31:0] rsp_ip_ff, rsp_ip_in;
   logic [47:0] rsp_mac_ff, rsp_mac_in;
   logic        rsp_rel_ff, rsp_rel_in;
   logic        rsp_last_ff, rsp_last_in;

   logic              c_we;
   logic [CIDX_W-1:0] c_waddr;
   cache_entry_type   c_wdata;
   cache_entry_type   c_rdata;
   logic              p_we;
   logic [PIDX_W-1:0] p_waddr;
   pend_entry_type    p_wdata;
   pend_entry_type    p_rdata;

   logic can_push;
   logic p_act;
   logic p_due;

   arpc_ram #(.DEPTH(CACHE_ENTRIES), .WIDTH($bits(cache_entry_type))) u_cache_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (cidx_ff[CIDX_W-1:0]),
      .rdata (c_rdata)
   );

   arpc_ram #(.DEPTH(PENDING_ENTRIES), .WIDTH($bits(pend_entry_type))) u_pend_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (pidx_ff),
      .rdata (p_rdata)
   );

   assign can_push = !rsp_valid_ff || rsp_tready;
   assign p_due = (p_rdata.tries == 3'd0) || ((now_ff - p_rdata.sent) > {24'd0, resend_ff});
   assign p_act = pvalid_ff[pidx_ff] && p_due;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      now_in        = now_ff;
      cvalid_in     = cvalid_ff;
      pvalid_in     = pvalid_ff;
      cidx_in       = cidx_ff;
      stg_valid_in  = 1'b0;
      stg_idx_in    = stg_idx_ff;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hit_mac_in    = hit_mac_ff;
      rel_in        = rel_ff;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_ev_in    = hold_ev_ff;
      hold_ip_in    = hold_ip_ff;
      hold_mac_in   = hold_mac_ff;
      hold_rel_in   = hold_rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_ev_in     = rsp_ev_ff;
      rsp_ip_in     = rsp_ip_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_last_in   = rsp_last_ff;
      c_we          = 1'b0;
      c_waddr       = cidx_ff[CIDX_W-1:0];
      c_wdata       = '{ip: ip_ff, mac: mac_ff, added: now_ff};
      p_we          = 1'b0;
      p_waddr       = pidx_ff;
      p_wdata       = '{ip: p_rdata.ip, sent: now_ff, tries: p_rdata.tries + 3'd1};
      req_tready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in    = kind_type'(req_tuser);
               ip_in      = req_tdata[31:0];
               mac_in     = req_tdata[79:32];
               cidx_in    = '0;
               pidx_in    = '0;
               hit_in     = 1'b0;
               hit_mac_in = '0;
               rel_in     = 1'b0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               unique case (kind_type'(req_tuser))
                  KIND_LOOKUP: state_in = ST_CSCAN;
                  KIND_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_CSCAN;
                  end
                  KIND_INSERT, KIND_QUEUE: state_in = ST_PREAD;
               endcase
            end
         end

         ST_CSCAN: begin
            if (cidx_ff < (CIDX_W+1)'(CACHE_ENTRIES)) begin
               stg_valid_in = 1'b1;
               stg_idx_in   = cidx_ff[CIDX_W-1:0];
               cidx_in      = cidx_ff + 1'b1;
            end
            if (stg_valid_ff && cvalid_ff[stg_idx_ff]) begin
               if (kind_ff == KIND_LOOKUP) begin
                  if (c_rdata.ip == ip_ff) begin
                     hit_in     = 1'b1;
                     hit_mac_in = c_rdata.mac;
                  end
               end else if ((now_ff - c_rdata.added) > {16'd0, expiry_ff}) begin
                  cvalid_in[stg_idx_ff] = 1'b0;
               end
            end
            if (stg_valid_ff && stg_idx_ff == CIDX_W'(CACHE_ENTRIES-1)) begin
               stg_valid_in = 1'b0;
               if (kind_ff == KIND_LOOKUP) begin
                  hold_valid_in = 1'b1;
                  hold_ev_in    = hit_in ? EV_HIT : EV_MISS;
                  hold_ip_in    = ip_ff;
                  hold_mac_in   = hit_in ? hit_mac_in : 48'd0;
                  hold_rel_in   = 1'b0;
                  state_in      = ST_FLUSH;
               end else begin
                  pidx_in  = '0;
                  state_in = ST_PREAD;
               end
            end
         end

         ST_PREAD: begin
            state_in = ST_PEXEC;
         end

         ST_PEXEC: begin
            priority case (kind_ff)
               KIND_INSERT: begin
                  if (pvalid_ff[pidx_ff] && p_rdata.ip == ip_ff && !rel_ff) begin
                     pvalid_in[pidx_ff] = 1'b0;
                     rel_in             = 1'b1;
                  end
               end
               KIND_QUEUE: begin
                  if (pvalid_ff[pidx_ff] && p_rdata.ip == ip_ff) begin
                     found_in = 1'b1;
                  end
                  if (!pvalid_ff[pidx_ff] && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pidx_ff;
                  end
               end
               default: begin
                  if (p_act) begin
                     if (hold_valid_ff && can_push) begin
                        rsp_valid_in = 1'b1;
                        rsp_ev_in    = hold_ev_ff;
                        rsp_ip_in    = hold_ip_ff;
                        rsp_mac_in   = 48'd0;
                        rsp_rel_in   = 1'b0;
                        rsp_last_in  = 1'b0;
                     end
                     hold_valid_in = 1'b1;
                     hold_ip_in    = p_rdata.ip;
                     hold_mac_in   = 48'd0;
                     hold_rel_in   = 1'b0;
                     if (p_rdata.tries >= tries_ff) begin
                        hold_ev_in         = EV_GIVEUP;
                        pvalid_in[pidx_ff] = 1'b0;
                     end else begin
                        hold_ev_in = EV_SEND;
                        p_we       = 1'b1;
                     end
                  end
               end
            endcase
            if (kind_ff == KIND_TICK && p_act && hold_valid_ff && !can_push) begin
               state_in      = ST_PEXEC;
               hold_valid_in = hold_valid_ff;
               hold_ev_in    = hold_ev_ff;
               hold_ip_in    = hold_ip_ff;
               pvalid_in     = pvalid_ff;
               p_we          = 1'b0;
            end else if (pidx_ff == PIDX_W'(PENDING_ENTRIES-1)) begin
               cidx_in = '0;
               unique case (kind_ff)
                  KIND_INSERT:            state_in = ST_FREE;
                  KIND_QUEUE:             state_in = ST_QEND;
                  KIND_TICK, KIND_LOOKUP: state_in = ST_FLUSH;
               endcase
            end else begin
               pidx_in  = pidx_ff + 1'b1;
               state_in = ST_PREAD;
            end
         end

         ST_FREE: begin
            hold_ip_in  = ip_ff;
            hold_mac_in = 48'd0;
            hold_rel_in = rel_ff;
            if (!cvalid_ff[cidx_ff[CIDX_W-1:0]]) begin
               c_we                            = 1'b1;
               cvalid_in[cidx_ff[CIDX_W-1:0]]  = 1'b1;
               hold_valid_in                   = 1'b1;
               hold_ev_in                      = EV_INSERTED;
               state_in                        = ST_FLUSH;
            end else if (cidx_ff[CIDX_W-1:0] == CIDX_W'(CACHE_ENTRIES-1)) begin
               hold_valid_in = 1'b1;
               hold_ev_in    = EV_FULL;
               state_in      = ST_FLUSH;
            end else begin
               cidx_in = cidx_ff + 1'b1;
            end
         end

         ST_QEND: begin
            hold_valid_in = 1'b1;
            hold_ip_in    = ip_ff;
            hold_mac_in   = 48'd0;
            hold_rel_in   = 1'b0;
            p_waddr       = free_idx_ff;
            p_wdata       = '{ip: ip_ff, sent: 32'd0, tries: 3'd0};
            if (found_ff) begin
               hold_ev_in = EV_ALREADY;
            end else if (free_ok_ff) begin
               hold_ev_in             = EV_QUEUED;
               p_we                   = 1'b1;
               pvalid_in[free_idx_ff] = 1'b1;
            end else begin
               hold_ev_in = EV_QFULL;
            end
            state_in = ST_FLUSH;
         end

         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               rsp_valid_in  = 1'b1;
               rsp_ev_in     = hold_ev_ff;
               rsp_ip_in     = hold_ip_ff;
               rsp_mac_in    = hold_mac_ff;
               rsp_rel_in    = hold_rel_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         cvalid_ff     <= '0;
         pvalid_ff     <= '0;
         stg_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         expiry_ff     <= EXPIRY_RESET;
         resend_ff     <= RESEND_RESET;
         tries_ff      <= TRIES_RESET;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         cvalid_ff     <= cvalid_in;
         pvalid_ff     <= pvalid_in;
         stg_valid_ff  <= stg_valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_EXPIRY: expiry_ff <= csr_wdata;
               CSR_RESEND: resend_ff <= csr_wdata[7:0];
               CSR_TRIES:  tries_ff  <= csr_wdata[2:0];
               CSR_SPARE:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      cidx_ff     <= cidx_in;
      stg_idx_ff  <= stg_idx_in;
      pidx_ff     <= pidx_in;
      hit_ff      <= hit_in;
      hit_mac_ff  <= hit_mac_in;
      rel_ff      <= rel_in;
      found_ff    <= found_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      hold_ev_ff  <= hold_ev_in;
      hold_ip_ff  <= hold_ip_in;
      hold_mac_ff <= hold_mac_in;
      hold_rel_ff <= hold_rel_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_ip_ff   <= rsp_ip_in;
      rsp_mac_ff  <= rsp_mac_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_rel_ff, rsp_mac_ff, rsp_ip_ff, rsp_ev_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP cache checker
// Port-level assertions for the ARP cache, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpc_checker
   import arpc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tlast
);

   `ARPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "Result withdrawn before its transfer.")

   `ARPC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "Command taken while another is in progress.")

   `ARPC_ASSERT_IMP(a_event_range, clock, reset, rsp_tvalid, rsp_tdata[3:0] <= EV_GIVEUP, "Result carries an unknown event code.")

   `ARPC_ASSERT_IMP(a_single_last, clock, reset, rsp_tvalid && rsp_tdata[3:0] != EV_SEND && rsp_tdata[3:0] != EV_GIVEUP, rsp_tlast, "Single result of a command without last.")

   `ARPC_ASSERT_IMP(a_mac_zero, clock, reset, rsp_tvalid && rsp_tdata[3:0] != EV_HIT, rsp_tdata[83:36] == 48'd0, "MAC set on a result other than a hit.")

endmodule

bind arp_cache_with_request_retry arpc_checker u_arpc_checker (.*);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// ARP cache testbench
// Drives lookup, insert, queue and tick commands into the ARP cache, predicts
// every result from a behavioural copy of the cache and pending tables, and
// compares each response transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top
   import arpc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      event_type   ev;
      logic [31:0] ip;
      logic [47:0] mac;
      logic        rel;
      logic        lst;
   } arp_result_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] ip;
      logic [47:0] mac;
      logic        typed;
      event_type   ev;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   arp_cache_with_request_retry dut (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic [15:0] expiry;
   logic [7:0]  resend;
   logic [2:0]  tries_max;
   logic [31:0] now_s;
   logic        c_valid [CACHE_ENTRIES];
   logic [31:0] c_ip    [CACHE_ENTRIES];
   logic [47:0] c_mac   [CACHE_ENTRIES];
   logic [31:0] c_added [CACHE_ENTRIES];
   logic        p_valid [PENDING_ENTRIES];
   logic [31:0] p_ip    [PENDING_ENTRIES];
   logic [31:0] p_sent  [PENDING_ENTRIES];
   logic [2:0]  p_tries [PENDING_ENTRIES];

   arp_result_type expected_results[$];
   int  failures = 0;
   int  results_seen = 0;
   int  sweep_results = 0;
   int  cycles = 0;
   logic rx_hold = 1'b0;
   logic [31:0] ip_pool[8];

   function automatic arp_result_type mk(event_type ev, logic [31:0] ip,
                                         logic [47:0] mac, logic rel, logic lst);
      arp_result_type r;
      r.ev = ev; r.ip = ip; r.mac = mac; r.rel = rel; r.lst = lst;
      return r;
   endfunction

   task automatic predict_command(kind_type kind, logic [31:0] ip, logic [47:0] mac);
      int hit;
      int slot;
      logic rel;
      int n;
      logic due;
      hit = -1; slot = -1; rel = 1'b0; n = 0;
      case (kind)
         KIND_LOOKUP: begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (c_valid[i] && c_ip[i] == ip) hit = i;
            if (hit >= 0) expected_results.push_back(mk(EV_HIT, ip, c_mac[hit], 1'b0, 1'b1));
            else expected_results.push_back(mk(EV_MISS, ip, '0, 1'b0, 1'b1));
         end
         KIND_INSERT: begin
            for (int i = 0; i < PENDING_ENTRIES; i++)
               if (!rel && p_valid[i] && p_ip[i] == ip) begin
                  p_valid[i] = 1'b0;
                  rel = 1'b1;
               end
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (slot < 0 && !c_valid[i]) slot = i;
            if (slot < 0) begin
               expected_results.push_back(mk(EV_FULL, ip, '0, rel, 1'b1));
            end else begin
               c_valid[slot] = 1'b1; c_ip[slot] = ip;
               c_mac[slot] = mac; c_added[slot] = now_s;
               expected_results.push_back(mk(EV_INSERTED, ip, '0, rel, 1'b1));
            end
         end
         KIND_QUEUE: begin
            for (int i = 0; i < PENDING_ENTRIES; i++)
               if (p_valid[i] && p_ip[i] == ip) hit = i;
            if (hit >= 0) begin
               expected_results.push_back(mk(EV_ALREADY, ip, '0, 1'b0, 1'b1));
            end else begin
               for (int i = 0; i < PENDING_ENTRIES; i++)
                  if (slot < 0 && !p_valid[i]) slot = i;
               if (slot < 0) begin
                  expected_results.push_back(mk(EV_QFULL, ip, '0, 1'b0, 1'b1));
               end else begin
                  p_valid[slot] = 1'b1; p_ip[slot] = ip;
                  p_sent[slot] = '0; p_tries[slot] = '0;
                  expected_results.push_back(mk(EV_QUEUED, ip, '0, 1'b0, 1'b1));
               end
            end
         end
         default: begin
            now_s = now_s + 32'd1;
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (c_valid[i] && (now_s - c_added[i]) > {16'd0, expiry})
                  c_valid[i] = 1'b0;
            for (int i = 0; i < PENDING_ENTRIES; i++) begin
               if (p_valid[i]) begin
                  due = (p_tries[i] == 0) || ((now_s - p_sent[i]) > {24'd0, resend});
                  if (due) begin
                     if (p_tries[i] >= tries_max) begin
                        p_valid[i] = 1'b0;
                        expected_results.push_back(mk(EV_GIVEUP, p_ip[i], '0, 1'b0, 1'b0));
                     end else begin
                        p_sent[i] = now_s;
                        p_tries[i] = p_tries[i] + 3'd1;
                        expected_results.push_back(mk(EV_SEND, p_ip[i], '0, 1'b0, 1'b0));
                     end
                     n++;
                  end
               end
            end
            if (n > 0) expected_results[$].lst = 1'b1;
            sweep_results += n;
         end
      endcase
   endtask

   task automatic send_command(kind_type kind, logic [31:0] ip, logic [47:0] mac);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap + 1) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {mac, ip};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_command(kind, ip, mac);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_EXPIRY: expiry = value;
         CSR_RESEND: resend = value[7:0];
         CSR_TRIES:  tries_max = value[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_command(int mode);
      int r;
      logic [31:0] ip;
      logic [47:0] mac;
      r = $urandom_range(0, 99);
      ip = ($urandom_range(0, 4) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
      mac = {16'($urandom()), $urandom()};
      if (mode == 1) begin
         if (r < 60) send_command(KIND_INSERT, $urandom(), mac);
         else send_command(KIND_QUEUE, $urandom(), mac);
      end else if (r < 25) send_command(KIND_LOOKUP, ip, mac);
      else if (r < 45) send_command(KIND_INSERT, ip, mac);
      else if (r < 70) send_command(KIND_QUEUE, ip, mac);
      else send_command(KIND_TICK, $urandom(), mac);
   endtask

   // Receiver: random stalls, plus a long hold-off requested by the sender.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
         if (stall > 0 || rx_hold) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rx_hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      arp_result_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer, event %0d", rsp_tdata[3:0]);
            failures++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_tdata[3:0] !== e.ev) begin
               $error("event_res expected %0d actual %0d", e.ev, rsp_tdata[3:0]);
               failures++;
            end
            if (rsp_tdata[35:4] !== e.ip) begin
               $error("addr_ip expected %h actual %h", e.ip, rsp_tdata[35:4]);
               failures++;
            end
            if (rsp_tdata[83:36] !== e.mac) begin
               $error("addr_mac expected %h actual %h", e.mac, rsp_tdata[83:36]);
               failures++;
            end
            if (rsp_tdata[84] !== e.rel) begin
               $error("released expected %0d actual %0d", e.rel, rsp_tdata[84]);
               failures++;
            end
            if (rsp_tlast !== e.lst) begin
               $error("last expected %0d actual %0d", e.lst, rsp_tlast);
               failures++;
            end
         end
      end
      if (cycles > 1500000) begin
         $display("status: fail");
         $finish;
      end
   end

   stim_row_type directed[$];

   initial begin
      expiry = EXPIRY_RESET; resend = RESEND_RESET; tries_max = TRIES_RESET;
      now_s = '0;
      foreach (c_valid[i]) c_valid[i] = 1'b0;
      foreach (p_valid[i]) p_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
      ip_pool[0] = '0; ip_pool[1] = '1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         '{KIND_LOOKUP, 32'h0, 48'h0, 1'b1, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, EV_INSERTED},
         '{KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0, EV_MISS},
         '{KIND_INSERT, 32'h0, 48'h0, 1'b1, EV_INSERTED},
         '{KIND_INSERT, 32'h0, 48'h1234_5678_9ABC, 1'b0, EV_MISS},
         '{KIND_LOOKUP, 32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_QUEUE,  32'hC0A8_0001, 48'h0, 1'b1, EV_QUEUED},
         '{KIND_QUEUE,  32'hC0A8_0001, 48'h0, 1'b1, EV_ALREADY},
         '{KIND_QUEUE,  32'h0A00_0002, 48'h0, 1'b1, EV_QUEUED},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_INSERT, 32'hC0A8_0001, 48'hAAAA_5555_AAAA, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_TICK,   32'h0, 48'h0, 1'b0, EV_MISS},
         '{KIND_LOOKUP, 32'hC0A8_0001, 48'h0, 1'b0, EV_MISS}
      };
      foreach (directed[i]) begin
         send_command(directed[i].kind, directed[i].ip, directed[i].mac);
         if (directed[i].typed && expected_results[$].ev !== directed[i].ev) begin
            $error("event_res of row %0d expected %0d predicted %0d", i,
                   directed[i].ev, expected_results[$].ev);
            failures++;
         end
      end
      wait_idle();

      // Short expiry, eager resend, immediate give-up.
      write_csr(CSR_EXPIRY, 16'd0);
      write_csr(CSR_RESEND, 16'd0);
      write_csr(CSR_TRIES, 16'd0);
      for (int i = 0; i < 30; i++) random_command(0);
      wait_idle();

      // Fill the pending table and load the cache with inserts; the receiver holds off meanwhile.
      write_csr(CSR_EXPIRY, 16'hFFFF);
      write_csr(CSR_RESEND, 16'd255);
      write_csr(CSR_TRIES, 16'd7);
      rx_hold = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            rx_hold = 1'b0;
         end
      join_none
      for (int i = 0; i < 150; i++) random_command(1);
      for (int i = 0; i < 10; i++) send_command(KIND_TICK, '0, '0);
      wait_idle();

      write_csr(CSR_EXPIRY, 16'd3);
      write_csr(CSR_RESEND, 16'd1);
      write_csr(CSR_TRIES, 16'd2);
      for (int i = 0; i < 10; i++) send_command(KIND_TICK, '0, '0);
      for (int i = 0; i < 50; i++) random_command(0);
      wait_idle();

      $display("Covered %0d results, %0d of them from pending sweeps, over %0d cycles.",
               results_seen, sweep_results, cycles);
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
